// ===== design/rsnh_pkg.sv =====
// shared types and constants for the ray sphere nearest hit block
package rsnh_pkg;

    localparam logic [25:0] MAX_DIST  = 26'd65536000;
    localparam logic [32:0] DIST_LIM  = 33'd65536000;
    localparam logic [30:0] RAD_RESET = 31'd32768;

    localparam logic [3:0] REG_ORG_X = 4'd0;
    localparam logic [3:0] REG_ORG_Y = 4'd1;
    localparam logic [3:0] REG_ORG_Z = 4'd2;
    localparam logic [3:0] REG_DIR_X = 4'd3;
    localparam logic [3:0] REG_DIR_Y = 4'd4;
    localparam logic [3:0] REG_DIR_Z = 4'd5;
    localparam logic [3:0] REG_RAD   = 4'd6;
    localparam logic [3:0] REG_EXCL  = 4'd7;

    typedef enum logic [4:0] {
        S_IDLE, S_LMUL, S_LACC, S_LCHK, S_LSQ, S_LSQW, S_DIV, S_DIVW,
        S_ECHK, S_EMUL, S_EACC, S_EMUL2, S_EACC2, S_BCALC,
        S_BL2, S_BL2A, S_BHL, S_BHLA, S_R2, S_R2A, S_DISC, S_DSQ, S_DSQW, S_FIN
    } t_state;

    typedef enum logic [2:0] {
        M_DSQ, M_OCSQ, M_DOT, M_BL2, M_BHL, M_R2
    } t_msel;

    typedef enum logic [2:0] {
        A_NONE, A_SS, A_DOT, A_B2LO, A_B2HI, A_R2
    } t_acc;

    typedef struct packed {
        logic       latch;
        t_msel      msel;
        logic [1:0] k;
        t_acc       acc;
        logic       clr;
        logic       set_start;
        logic       sq_start;
        logic       sq_disc;
        logic       len_store;
        logic       dv_start;
        logic       u_store;
        logic       b_calc;
        logic       d_calc;
        logic       upd;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic ss_zero;
        logic busy;
        logic started;
        logic process;
        logic hit;
        logic last;
        logic out_free;
    } t_stat;

endpackage

// ===== design/rsnh_ctrl.sv =====
// controller state machine sequencing the datapath
module rsnh_ctrl
    import rsnh_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= 2'd0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.msel = M_DSQ;
        o_cmd.acc  = A_NONE;
        o_cmd.k    = r_k;
        o_cmd.clr  = (r_k == 2'd0);
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                n_k        = 2'd0;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = i_stat.started ? S_ECHK : S_LMUL;
                end
            end
            S_LMUL: begin
                o_cmd.msel = M_DSQ;
                n_state    = S_LACC;
            end
            S_LACC: begin
                o_cmd.acc = A_SS;
                if (r_k == 2'd2) begin
                    n_k     = 2'd0;
                    n_state = S_LCHK;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_LMUL;
                end
            end
            S_LCHK: begin
                o_cmd.set_start = 1'b1;
                n_state = i_stat.ss_zero ? S_ECHK : S_LSQ;
            end
            S_LSQ: begin
                o_cmd.sq_start = 1'b1;
                n_state        = S_LSQW;
            end
            S_LSQW: begin
                if (!i_stat.busy) begin
                    o_cmd.len_store = 1'b1;
                    n_k             = 2'd0;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.dv_start = 1'b1;
                n_state        = S_DIVW;
            end
            S_DIVW: begin
                if (!i_stat.busy) begin
                    o_cmd.u_store = 1'b1;
                    if (r_k == 2'd2) begin
                        n_k     = 2'd0;
                        n_state = S_ECHK;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = S_DIV;
                    end
                end
            end
            S_ECHK: begin
                n_k     = 2'd0;
                n_state = i_stat.process ? S_EMUL : S_FIN;
            end
            S_EMUL: begin
                o_cmd.msel = M_DOT;
                n_state    = S_EACC;
            end
            S_EACC: begin
                o_cmd.acc = A_DOT;
                n_state   = S_EMUL2;
            end
            S_EMUL2: begin
                o_cmd.msel = M_OCSQ;
                n_state    = S_EACC2;
            end
            S_EACC2: begin
                o_cmd.acc = A_SS;
                if (r_k == 2'd2) begin
                    n_k     = 2'd0;
                    n_state = S_BCALC;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_EMUL;
                end
            end
            S_BCALC: begin
                o_cmd.b_calc = 1'b1;
                n_state      = S_BL2;
            end
            S_BL2: begin
                o_cmd.msel = M_BL2;
                n_state    = S_BL2A;
            end
            S_BL2A: begin
                o_cmd.acc = A_B2LO;
                n_state   = S_BHL;
            end
            S_BHL: begin
                o_cmd.msel = M_BHL;
                n_state    = S_BHLA;
            end
            S_BHLA: begin
                o_cmd.acc = A_B2HI;
                n_state   = S_R2;
            end
            S_R2: begin
                o_cmd.msel = M_R2;
                n_state    = S_R2A;
            end
            S_R2A: begin
                o_cmd.acc = A_R2;
                n_state   = S_DISC;
            end
            S_DISC: begin
                o_cmd.d_calc = 1'b1;
                n_state      = S_DSQ;
            end
            S_DSQ: begin
                if (i_stat.hit) begin
                    o_cmd.sq_start = 1'b1;
                    o_cmd.sq_disc  = 1'b1;
                    n_state        = S_DSQW;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DSQW: begin
                if (!i_stat.busy) begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_stat.last) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/rsnh_dp.sv =====
// datapath: configuration, shared multiplier, square root, divider, nearest hit
module rsnh_dp
    import rsnh_pkg::*;
#(
    parameter int CMP_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    input  logic [15:0] i_entity_id,
    input  logic [31:0] i_center_x,
    input  logic [31:0] i_center_y,
    input  logic [31:0] i_center_z,
    input  logic        i_last_entity,
    input  logic        i_out_ready,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_out_valid,
    output logic [15:0] o_hit_id
);

    logic signed [31:0] r_org [3];
    logic signed [31:0] r_dir [3];
    logic [30:0]        r_rad;
    logic [15:0]        r_excl;

    logic [CMP_BITS-1:0] r_id;
    logic signed [31:0]  r_c [3];
    logic                r_last;

    logic signed [31:0] r_u [3];
    logic               r_started, r_dzero;
    logic [CMP_BITS-1:0] r_best_id;
    logic [25:0]        r_best;

    logic [63:0]        r_prod;
    logic               r_prod_neg;
    logic [63:0]        r_ss, r_b2, r_r2, r_disc;
    logic signed [64:0] r_dot;
    logic [34:0]        r_bmag;
    logic               r_bneg, r_hit;
    logic [31:0]        r_len;

    logic [63:0] r_sv, r_sr, r_sb;
    logic [4:0]  r_cnt;
    logic        r_srun, r_drun;
    logic [31:0] r_drem;
    logic [30:0] r_dq;
    logic        r_din;

    logic        r_out_valid;
    logic [CMP_BITS-1:0] r_out_id;

    logic signed [32:0] oc   [3];
    logic [32:0]        ocm  [3];
    logic [31:0]        dirm [3];
    logic [30:0]        um   [3];
    logic [32:0]        lim;
    logic               in_range;

    logic [31:0] ocm_k, dirm_k, ma, mb;
    logic [30:0] um_k;
    logic        oc_neg_k, u_neg_k, dir_neg_k;
    logic [64:0] dmag;
    logic [63:0] ssum;
    logic [32:0] dtry, dlen;
    logic signed [35:0] bs;
    logic signed [36:0] t1, t2, tsel;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            oc[i]   = {r_org[i][31], r_org[i]} - {r_c[i][31], r_c[i]};
            ocm[i]  = oc[i][32] ? 33'(-oc[i]) : 33'(oc[i]);
            dirm[i] = r_dir[i][31] ? 32'(-r_dir[i]) : 32'(r_dir[i]);
            um[i]   = r_u[i][31] ? 31'(-r_u[i]) : 31'(r_u[i]);
        end
        lim      = {2'b00, r_rad} + DIST_LIM;
        in_range = (ocm[0] <= lim) && (ocm[1] <= lim) && (ocm[2] <= lim);
    end

    always_comb begin
        case (i_cmd.k)
            2'd0: begin
                ocm_k = ocm[0][31:0]; dirm_k = dirm[0]; um_k = um[0];
                oc_neg_k = oc[0][32]; u_neg_k = r_u[0][31]; dir_neg_k = r_dir[0][31];
            end
            2'd1: begin
                ocm_k = ocm[1][31:0]; dirm_k = dirm[1]; um_k = um[1];
                oc_neg_k = oc[1][32]; u_neg_k = r_u[1][31]; dir_neg_k = r_dir[1][31];
            end
            default: begin
                ocm_k = ocm[2][31:0]; dirm_k = dirm[2]; um_k = um[2];
                oc_neg_k = oc[2][32]; u_neg_k = r_u[2][31]; dir_neg_k = r_dir[2][31];
            end
        endcase
        case (i_cmd.msel)
            M_DSQ:   begin ma = dirm_k;             mb = dirm_k;             end
            M_OCSQ:  begin ma = ocm_k;              mb = ocm_k;              end
            M_DOT:   begin ma = ocm_k;              mb = {1'b0, um_k};       end
            M_BL2:   begin ma = r_bmag[31:0];       mb = r_bmag[31:0];       end
            M_BHL:   begin ma = {29'd0, r_bmag[34:32]}; mb = r_bmag[31:0];   end
            M_R2:    begin ma = {1'b0, r_rad};      mb = {1'b0, r_rad};      end
            default: begin ma = '0;                 mb = '0;                 end
        endcase
        dmag = r_dot[64] ? 65'(-r_dot) : 65'(r_dot);
        ssum = r_sr + r_sb;
        dtry = {r_drem, r_din};
        dlen = {1'b0, r_len};
        bs   = r_bneg ? -$signed({1'b0, r_bmag}) : $signed({1'b0, r_bmag});
        t1   = -$signed({bs[35], bs}) - $signed({5'd0, r_sr[31:0]});
        t2   = -$signed({bs[35], bs}) + $signed({5'd0, r_sr[31:0]});
        tsel = t1[36] ? t2 : t1;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_org[i] <= '0;
                r_dir[i] <= '0;
            end
            r_rad  <= RAD_RESET;
            r_excl <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_ORG_X: r_org[0] <= i_cfg_data;
                REG_ORG_Y: r_org[1] <= i_cfg_data;
                REG_ORG_Z: r_org[2] <= i_cfg_data;
                REG_DIR_X: r_dir[0] <= i_cfg_data;
                REG_DIR_Y: r_dir[1] <= i_cfg_data;
                REG_DIR_Z: r_dir[2] <= i_cfg_data;
                REG_RAD:   r_rad    <= i_cfg_data[30:0];
                REG_EXCL:  r_excl   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // item capture, multiplier and accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_id   <= i_entity_id[CMP_BITS-1:0];
            r_c[0] <= i_center_x;
            r_c[1] <= i_center_y;
            r_c[2] <= i_center_z;
            r_last <= i_last_entity;
        end
        r_prod     <= ma * mb;
        r_prod_neg <= oc_neg_k ^ u_neg_k;
        case (i_cmd.acc)
            A_SS:    r_ss  <= (i_cmd.clr ? 64'd0 : r_ss) + r_prod;
            A_DOT:   r_dot <= (i_cmd.clr ? 65'sd0 : r_dot) +
                              (r_prod_neg ? -$signed({1'b0, r_prod}) : $signed({1'b0, r_prod}));
            A_B2LO:  r_b2  <= r_prod;
            A_B2HI:  r_b2  <= r_b2 + {r_prod[30:0], 1'b0, 32'd0};
            A_R2:    r_r2  <= r_prod;
            default: begin
            end
        endcase
        if (i_cmd.b_calc) begin
            r_bmag <= dmag[64:30];
            r_bneg <= r_dot[64];
        end
        if (i_cmd.d_calc) begin
            if (r_ss >= r_b2) begin
                r_hit  <= (r_ss - r_b2) <= r_r2;
                r_disc <= r_r2 - (r_ss - r_b2);
            end else begin
                r_hit  <= 1'b1;
                r_disc <= ((r_b2 - r_ss) > ~r_r2) ? '1 : r_r2 + (r_b2 - r_ss);
            end
        end
        if (i_cmd.len_store) begin
            r_len <= r_sr[31:0];
        end
    end

    // square root and divider, one step a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srun <= 1'b0;
            r_drun <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.sq_start) begin
                r_sv   <= i_cmd.sq_disc ? r_disc : r_ss;
                r_sr   <= '0;
                r_sb   <= 64'h4000_0000_0000_0000;
                r_cnt  <= 5'd31;
                r_srun <= 1'b1;
            end else if (r_srun) begin
                if (r_sv >= ssum) begin
                    r_sv <= r_sv - ssum;
                    r_sr <= (r_sr >> 1) + r_sb;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sb  <= r_sb >> 2;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_srun <= 1'b0;
                end
            end
            if (i_cmd.dv_start) begin
                r_drem <= {1'b0, dirm_k[31:1]};
                r_din  <= dirm_k[0];
                r_dq   <= '0;
                r_cnt  <= 5'd30;
                r_drun <= 1'b1;
            end else if (r_drun) begin
                if (dtry >= dlen) begin
                    r_drem <= 32'(dtry - dlen);
                    r_dq   <= {r_dq[29:0], 1'b1};
                end else begin
                    r_drem <= dtry[31:0];
                    r_dq   <= {r_dq[29:0], 1'b0};
                end
                r_din <= 1'b0;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_drun <= 1'b0;
                end
            end
        end
    end

    // query state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_u[i] <= '0;
            end
            r_started   <= 1'b0;
            r_dzero     <= 1'b0;
            r_best_id   <= '0;
            r_best      <= MAX_DIST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.set_start) begin
                r_started <= 1'b1;
                r_dzero   <= (r_ss == 64'd0);
                if (r_ss == 64'd0) begin
                    for (int i = 0; i < 3; i++) begin
                        r_u[i] <= '0;
                    end
                end
            end
            if (i_cmd.u_store) begin
                case (i_cmd.k)
                    2'd0:    r_u[0] <= dir_neg_k ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
                    2'd1:    r_u[1] <= dir_neg_k ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
                    default: r_u[2] <= dir_neg_k ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
                endcase
            end
            if (i_cmd.upd && !tsel[36] && (tsel < $signed({11'd0, r_best}))) begin
                r_best    <= tsel[25:0];
                r_best_id <= r_id;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_out_id    <= r_dzero ? '0 : r_best_id;
                r_best_id   <= '0;
                r_best      <= MAX_DIST;
                r_started   <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.ss_zero  = (r_ss == 64'd0);
        o_stat.busy     = r_srun | r_drun;
        o_stat.started  = r_started;
        o_stat.process  = !r_dzero && (r_id != '0) && (r_id != r_excl[CMP_BITS-1:0]) &&
                          in_range;
        o_stat.hit      = r_hit;
        o_stat.last     = r_last;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_hit_id    = 16'(r_out_id);

endmodule

// ===== design/ray_sphere_nearest_hit.sv =====
// top level of the ray sphere nearest hit block
// Entities stream in one at a time; each is tested against the ray and the nearest
// hit below 1000.0 is kept, and the item flagged last_entity produces one hit_id (0 if
// none). The first item of a query first runs the direction setup: three squares, a
// 32-step square root for the direction length and three 31-step divides. Then a
// skipped or culled entity goes straight to the finish state, a tested one runs the
// multiplies for b and the discriminant, and one that hits also runs the 32-step
// square root of the discriminant on the shared root unit. A finished hit_id waits
// in an output register while the next entity is taken in; a last entity that finds
// that register still full holds the input until the waiting result is taken.
module ray_sphere_nearest_hit
    import rsnh_pkg::*;
#(
    parameter int ID_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_entity_id,
    input  logic [31:0] i_center_x,
    input  logic [31:0] i_center_y,
    input  logic [31:0] i_center_z,
    input  logic        i_last_entity,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_hit_id
);

    localparam int CMP_BITS = (ID_BITS < 16) ? ID_BITS : 16;

    t_cmd  cmd;
    t_stat stat;

    rsnh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    rsnh_dp #(
        .CMP_BITS (CMP_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_entity_id   (i_entity_id),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_center_z    (i_center_z),
        .i_last_entity (i_last_entity),
        .i_out_ready   (i_out_ready),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .o_hit_id      (o_hit_id)
    );

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for ray_sphere_nearest_hit with a fixed-point nearest hit predictor
`timescale 1ns / 1ps

module testbench
    import rsnh_pkg::*;
();

    localparam int          CYCLE_LIMIT = 2000000;
    localparam int          DRAIN_WAIT  = 300;
    localparam int          LONG_HOLD   = 3000;
    localparam logic [3:0]  REG_UNUSED  = 4'd9;
    localparam longint      FAR_DIST    = 64'd65536000;
    localparam logic [31:0] ONE         = 32'h0001_0000;

    typedef struct {
        logic [15:0] id;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic        last;
    } t_entity;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_addr;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_entity_id;
    logic [31:0] i_center_x;
    logic [31:0] i_center_y;
    logic [31:0] i_center_z;
    logic        i_last_entity;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_hit_id;

    t_entity     pending[$];
    logic [15:0] hit_ids[$];

    logic [31:0] shadow_reg[8];
    longint      unit_x, unit_y, unit_z;
    longint      near_dist;
    logic [15:0] near_id;
    bit          started;
    bit          dir_zero;

    int          errors;
    int          cycles;
    int          idle_mode;
    bit          hold_req;
    int          hold_left;

    ray_sphere_nearest_hit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_entity_id  (i_entity_id),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_center_z   (i_center_z),
        .i_last_entity(i_last_entity),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hit_id     (o_hit_id)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unit_comp(input longint d, input longint unsigned len);
        longint unsigned q;
        q = (magnitude(d) << 30) / len;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    // advances the query state for one entity; returns 1 when a hit id is due
    function automatic bit nearest_hit_step(input t_entity e, output logic [15:0] hit);
        longint          dx, dy, dz, ox, oy, oz, rad, lim, dotp, b, sq, t;
        longint unsigned ss, len, oc2, b2, r2, disc, diff, extra;
        bit              hit_ok;
        hit = '0;
        if (!started) begin
            dx = $signed(shadow_reg[REG_DIR_X]);
            dy = $signed(shadow_reg[REG_DIR_Y]);
            dz = $signed(shadow_reg[REG_DIR_Z]);
            ss = magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy)
               + magnitude(dz) * magnitude(dz);
            started = 1'b1;
            if (ss == 0) begin
                dir_zero = 1'b1;
                unit_x = 0;
                unit_y = 0;
                unit_z = 0;
            end else begin
                len = int_sqrt(ss);
                dir_zero = 1'b0;
                unit_x = unit_comp(dx, len);
                unit_y = unit_comp(dy, len);
                unit_z = unit_comp(dz, len);
            end
        end
        if (!dir_zero && e.id != 0 && e.id != shadow_reg[REG_EXCL][15:0]) begin
            rad = shadow_reg[REG_RAD][30:0];
            lim = rad + FAR_DIST;
            ox = longint'($signed(shadow_reg[REG_ORG_X])) - longint'($signed(e.cx));
            oy = longint'($signed(shadow_reg[REG_ORG_Y])) - longint'($signed(e.cy));
            oz = longint'($signed(shadow_reg[REG_ORG_Z])) - longint'($signed(e.cz));
            if (magnitude(ox) <= lim && magnitude(oy) <= lim && magnitude(oz) <= lim) begin
                dotp = ox * unit_x + oy * unit_y + oz * unit_z;
                b = dotp / 1073741824;
                oc2 = magnitude(ox) * magnitude(ox) + magnitude(oy) * magnitude(oy)
                    + magnitude(oz) * magnitude(oz);
                b2 = magnitude(b) * magnitude(b);
                r2 = longint'(rad) * longint'(rad);
                hit_ok = 1'b1;
                disc = 0;
                if (oc2 >= b2) begin
                    diff = oc2 - b2;
                    if (diff > r2) hit_ok = 1'b0;
                    else disc = r2 - diff;
                end else begin
                    extra = b2 - oc2;
                    disc = (extra > ~64'd0 - r2) ? ~64'd0 : r2 + extra;
                end
                if (hit_ok) begin
                    sq = int_sqrt(disc);
                    t = -b - sq;
                    if (t < 0) t = -b + sq;
                    if (t >= 0 && t < near_dist) begin
                        near_dist = t;
                        near_id = e.id;
                    end
                end
            end
        end
        if (e.last) begin
            hit = dir_zero ? 16'd0 : near_id;
            near_id = '0;
            near_dist = FAR_DIST;
            started = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("ray_sphere_nearest_hit verification failed");
            $finish;
        end
    end

    // sender
    always @(posedge i_clk) begin : drive
        t_entity     cur;
        t_entity     nxt;
        logic [15:0] want;
        bit          take;
        int          idle_pct;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            take = 1'b0;
            if (i_in_valid && o_in_ready) begin
                cur.id = i_entity_id;
                cur.cx = i_center_x;
                cur.cy = i_center_y;
                cur.cz = i_center_z;
                cur.last = i_last_entity;
                if (nearest_hit_step(cur, want)) hit_ids = {hit_ids, want};
                take = 1'b1;
            end
            if (!i_in_valid || take) begin
                idle_pct = (idle_mode == 1) ? 45 : (idle_mode == 3) ? 13 : 0;
                if (pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    nxt = pending.pop_front();
                    i_in_valid <= 1'b1;
                    i_entity_id <= nxt.id;
                    i_center_x <= nxt.cx;
                    i_center_y <= nxt.cy;
                    i_center_z <= nxt.cz;
                    i_last_entity <= nxt.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin : collect
        logic [15:0] want;
        int          stall_pct;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_left <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (hit_ids.size() == 0) begin
                    report_mismatch($sformatf("unexpected transfer hit_id=%0d", o_hit_id));
                end else begin
                    want = hit_ids.pop_front();
                    if (o_hit_id !== want)
                        report_mismatch($sformatf("hit_id %0d, want %0d", o_hit_id, want));
                end
            end
            stall_pct = (idle_mode == 2) ? 45 : (idle_mode == 3) ? 13 : 0;
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_left <= LONG_HOLD;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        if (idx == REG_RAD) shadow_reg[idx] = {1'b0, val[30:0]};
        else if (idx == REG_EXCL) shadow_reg[idx] = {16'd0, val[15:0]};
        else if (idx < 8) shadow_reg[idx] = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] v[8]);
        for (int k = 0; k < 8; k++) write_reg(k[3:0], v[k]);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending.size() != 0 || i_in_valid || hit_ids.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic push(input logic [15:0] id, input logic [31:0] x, input logic [31:0] y,
                        input logic [31:0] z, input logic last);
        t_entity e;
        e.id = id;
        e.cx = x;
        e.cy = y;
        e.cz = z;
        e.last = last;
        pending = {pending, e};
    endtask

    function automatic int spread(input int unsigned span);
        return int'($urandom_range(0, 2 * span)) - int'(span);
    endfunction

    // one query: mostly entities placed along the ray, plus noise and skipped ids
    task automatic push_query(output int count);
        int          n, sel;
        longint      s, nspan;
        logic [15:0] id;
        logic [31:0] c[3];
        n = $urandom_range(1, 6);
        nspan = longint'(shadow_reg[REG_RAD]);
        if (nspan > 64'd1048576) nspan = 64'd1048576;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            id = 16'($urandom_range(1, 20));
            for (int a = 0; a < 3; a++) begin
                s = longint'($urandom_range(0, 240));
                s = s - 20;
                c[a] = 32'(longint'($signed(shadow_reg[REG_ORG_X + a]))
                     + longint'($signed(shadow_reg[REG_DIR_X + a])) * s
                     + longint'(spread(32'(nspan))));
            end
            if (sel >= 70 && sel < 80) begin
                id = 16'($urandom);
                c[0] = $urandom;
                c[1] = $urandom;
                c[2] = $urandom;
            end else if (sel >= 80 && sel < 88) begin
                id = $urandom_range(0, 1) ? 16'd0 : shadow_reg[REG_EXCL][15:0];
            end else if (sel >= 88) begin
                c[$urandom_range(0, 2)] ^= 32'h4000_0000;
            end
            push(id, c[0], c[1], c[2], k == n - 1);
        end
        count = n;
    endtask

    initial begin : stimulus
        logic [31:0] cfg[8];
        int          items, got;
        errors = 0;
        cycles = 0;
        idle_mode = 0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_entity_id = '0;
        i_center_x = '0;
        i_center_y = '0;
        i_center_z = '0;
        i_last_entity = 1'b0;
        i_out_ready = 1'b0;
        for (int k = 0; k < 8; k++) shadow_reg[k] = '0;
        shadow_reg[REG_RAD] = {1'b0, RAD_RESET};
        unit_x = 0;
        unit_y = 0;
        unit_z = 0;
        near_id = '0;
        near_dist = FAR_DIST;
        started = 1'b0;
        dir_zero = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers leave a zero direction
        @(negedge i_clk);
        push(16'd1, 32'd0, 32'd0, 32'd0, 1'b0);
        push(16'd2, ONE, 32'd0, 32'd0, 1'b1);
        wait_drained();

        cfg = '{32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, ONE, 32'd5};
        write_all(cfg);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        @(negedge i_clk);
        push(16'd3, 10 * ONE, 32'd0, 32'd0, 1'b0);
        push(16'd7, 5 * ONE, 32'd0, 32'd0, 1'b0);
        push(16'd5, ONE, 32'd0, 32'd0, 1'b0);
        push(16'd0, 2 * ONE, 32'd0, 32'd0, 1'b0);
        push(16'd9, -3 * ONE, 32'd0, 32'd0, 1'b0);
        push(16'd11, 5 * ONE, 32'd0, 32'd0, 1'b1);
        push(16'd4, 32'd0, 32'd0, 32'd0, 1'b1);
        push(16'd6, 1001 * ONE + ONE / 2, 32'd0, 32'd0, 1'b0);
        push(16'd8, 2000 * ONE, 32'd0, 32'd0, 1'b0);
        push(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        push(16'd12, 3 * ONE, 5 * ONE, 32'd0, 1'b1);
        wait_drained();

        cfg = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF};
        write_all(cfg);
        @(negedge i_clk);
        push(16'hFFFF, 32'd0, 32'd0, 32'd0, 1'b0);
        push(16'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        push(16'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1'b0);
        push(16'h8000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
        wait_drained();

        for (int p = 0; p < 9; p++) begin
            for (int a = 0; a < 3; a++) begin
                cfg[a] = spread(32'd65536000);
                cfg[3 + a] = spread(32'd262144);
            end
            cfg[REG_RAD] = $urandom_range(16384, 393216);
            cfg[REG_EXCL] = $urandom_range(1, 20);
            if (p == 4) cfg[REG_RAD] = 32'd0;
            if (p == 6) for (int k = 0; k < 8; k++) cfg[k] = $urandom;
            write_all(cfg);
            @(negedge i_clk);
            idle_mode = p % 4;
            items = 0;
            while (items < 72) begin
                push_query(got);
                items += got;
            end
            if (p == 2) begin
                hold_req = 1'b1;
                @(negedge i_clk);
                @(negedge i_clk);
                hold_req = 1'b0;
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("ray_sphere_nearest_hit verification clean");
        end else begin
            $display("ray_sphere_nearest_hit verification failed");
        end
        $finish;
    end

endmodule

// ===== ray_sphere_nearest_hit.f =====
design/rsnh_pkg.sv
design/rsnh_ctrl.sv
design/rsnh_dp.sv
design/ray_sphere_nearest_hit.sv
sim/testbench.sv
